### rtl/kda_pkg.sv
// shared types and constants for the key debounce and auto-repeat block
package kda_pkg;

	localparam int KEY_W     = 4;
	localparam int DATA_W    = 8;
	localparam int CFG_IDX_W = 2;

	typedef logic [DATA_W-1:0]    data_t;
	typedef logic [KEY_W-1:0]     keys_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// register indexes of the configuration port
	localparam cfg_idx_t REG_SAMPLE_MASK  = 2'd0;
	localparam cfg_idx_t REG_OFF_FILL     = 2'd1;
	localparam cfg_idx_t REG_FIRST_DELAY  = 2'd2;
	localparam cfg_idx_t REG_REPEAT_DELAY = 2'd3;

	localparam data_t SAMPLE_MASK_RST  = 8'd15;
	localparam data_t OFF_FILL_RST     = 8'd0;
	localparam data_t FIRST_DELAY_RST  = 8'd10;
	localparam data_t REPEAT_DELAY_RST = 8'd3;

	typedef struct packed {
		data_t sample_mask;
		data_t off_fill;
		data_t first_delay;
		data_t repeat_delay;
	} cfg_t;

	// what one key lane found in the current item
	typedef struct packed {
		logic press;
		logic release_ev;
		logic repeat_ev;
		logic held;
	} lane_res_t;

endpackage

### rtl/kda_lane.sv
// one key lane: history shift register, held flag and repeat counter
module kda_lane
	import kda_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic      level,
	input  cfg_t      cfg,
	output lane_res_t res
);

	data_t hist_q;
	data_t cnt_q;
	logic  held_q;

	data_t     hist_d;
	data_t     cnt_d;
	logic      held_d;
	logic      match_shift;
	logic      match_now;
	data_t     cnt_dec;

	always_comb begin
		hist_d      = {hist_q[DATA_W-2:0], level};
		cnt_d       = cnt_q;
		held_d      = held_q;
		res         = '0;
		match_shift = (hist_d & cfg.sample_mask) == cfg.sample_mask;

		if (match_shift && !held_q) begin
			res.press = 1'b1;
			cnt_d     = cfg.first_delay;
			held_d    = 1'b1;
		end
		if (!match_shift && held_q) begin
			res.release_ev = 1'b1;
			hist_d         = cfg.off_fill;
			held_d         = 1'b0;
		end

		// count step looks at the history as it now stands (refill included)
		match_now = (hist_d & cfg.sample_mask) == cfg.sample_mask;
		cnt_dec   = cnt_d - data_t'(1);
		if (match_now && cnt_d != '0) begin
			cnt_d = cnt_dec;
			if (cnt_dec == '0) begin
				res.press      = 1'b0;
				res.release_ev = 1'b0;
				res.repeat_ev  = 1'b1;
				cnt_d          = cfg.repeat_delay;
				held_d         = 1'b1;
			end
		end
		res.held = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= OFF_FILL_RST;
			cnt_q  <= FIRST_DELAY_RST;
			held_q <= 1'b0;
		end else if (step) begin
			hist_q <= hist_d;
			cnt_q  <= cnt_d;
			held_q <= held_d;
		end
	end

endmodule

### rtl/kda_merge.sv
// gathers the lane results into the event fields and holds them in the output register
module kda_merge
	import kda_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  lane_res_t [NUM_KEYS-1:0] lane_res,
	input  logic                     event_stall,
	output logic                     event_valid,
	output keys_t                    press_events,
	output keys_t                    release_events,
	output keys_t                    repeat_events,
	output keys_t                    held_keys
);

	keys_t press_w;
	keys_t release_w;
	keys_t repeat_w;
	keys_t held_w;
	logic  valid_q;

	// keys past the field width drop out of the result
	for (genvar i = 0; i < KEY_W; i++) begin : g_pack
		if (i < NUM_KEYS) begin : g_key
			assign press_w[i]   = lane_res[i].press;
			assign release_w[i] = lane_res[i].release_ev;
			assign repeat_w[i]  = lane_res[i].repeat_ev;
			assign held_w[i]    = lane_res[i].held;
		end else begin : g_none
			assign press_w[i]   = 1'b0;
			assign release_w[i] = 1'b0;
			assign repeat_w[i]  = 1'b0;
			assign held_w[i]    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!event_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			press_events   <= press_w;
			release_events <= release_w;
			repeat_events  <= repeat_w;
			held_keys      <= held_w;
		end
	end

	assign event_valid = valid_q;

endmodule

### rtl/key_debounce_autorepeat_top.sv
// Key debounce with auto-repeat: each item is one scan tick carrying a level bit per key.
// Every key has its own lane (8-bit sample history, held flag, repeat counter) and all
// lanes update together, so one item is taken per clock while key_stall is low and its
// result appears in the output register in the next cycle. The only thing that slows intake is the output
// register: key_stall is high while a result sits there and event_stall holds it.
// Configuration writes are always taken (cfg_ready is tied high) and belong in idle time.
module key_debounce_autorepeat_top
	import kda_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     key_valid,
	output logic     key_stall,
	input  keys_t    key_levels,
	output logic     event_valid,
	input  logic     event_stall,
	output keys_t    press_events,
	output keys_t    release_events,
	output keys_t    repeat_events,
	output keys_t    held_keys,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  data_t    cfg_data
);

	cfg_t                     cfg_q;
	lane_res_t [NUM_KEYS-1:0] lane_res;
	logic                     step;

	assign cfg_ready = 1'b1;
	assign key_stall = event_valid && event_stall;
	assign step      = key_valid && !key_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_mask  <= SAMPLE_MASK_RST;
			cfg_q.off_fill     <= OFF_FILL_RST;
			cfg_q.first_delay  <= FIRST_DELAY_RST;
			cfg_q.repeat_delay <= REPEAT_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SAMPLE_MASK:  cfg_q.sample_mask  <= cfg_data;
				REG_OFF_FILL:     cfg_q.off_fill     <= cfg_data;
				REG_FIRST_DELAY:  cfg_q.first_delay  <= cfg_data;
				REG_REPEAT_DELAY: cfg_q.repeat_delay <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic level;
		if (k < KEY_W) begin : g_in
			assign level = key_levels[k];
		end else begin : g_zero
			assign level = 1'b0;
		end

		kda_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.level  (level),
			.cfg    (cfg_q),
			.res    (lane_res[k])
		);
	end

	kda_merge #(
		.NUM_KEYS (NUM_KEYS)
	) u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (step),
		.lane_res       (lane_res),
		.event_stall    (event_stall),
		.event_valid    (event_valid),
		.press_events   (press_events),
		.release_events (release_events),
		.repeat_events  (repeat_events),
		.held_keys      (held_keys)
	);

endmodule

### rtl/kda_checker.sv
// port-level checks for the key debounce block and their binding
module kda_checker
	import kda_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     key_valid,
	input logic     key_stall,
	input logic     event_valid,
	input logic     event_stall,
	input keys_t    press_events,
	input keys_t    release_events,
	input keys_t    repeat_events,
	input keys_t    held_keys
);

	// a key shows at most one event per item
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> ((press_events & release_events) == '0 &&
			(press_events & repeat_events) == '0 &&
			(release_events & repeat_events) == '0))
		else $error("more than one event for a key");

	// press and repeat leave the key held
	a_held_after: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> (((press_events | repeat_events) & ~held_keys) == '0))
		else $error("press or repeat without held flag");

	// a release leaves the key released
	a_release_clear: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> ((release_events & held_keys) == '0))
		else $error("release with held flag still set");

	// an accepted item always yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(key_valid && !key_stall) |=> event_valid)
		else $error("accepted item without result");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && event_stall) |=> (event_valid && $stable(press_events) &&
			$stable(release_events) && $stable(repeat_events) && $stable(held_keys)))
		else $error("stalled result changed");

endmodule

bind key_debounce_autorepeat_top kda_checker u_kda_checker (.*);

### bench/tb_key_debounce_autorepeat_top.sv
// testbench for the key debounce and auto-repeat block: scripted and random scan ticks
module tb_key_debounce_autorepeat_top;
	import kda_pkg::*;

	localparam int NKEYS       = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_MAX    = 40;

	typedef enum logic [1:0] {EV_NONE, EV_PRESS, EV_RELEASE, EV_REPEAT} key_ev_e;

	typedef struct packed {
		keys_t press;
		keys_t release_ev;
		keys_t repeat_ev;
		keys_t held;
	} scan_res_t;

	logic     clk         = 1'b0;
	logic     arst_n      = 1'b0;
	logic     key_valid   = 1'b0;
	keys_t    key_levels  = '0;
	logic     event_stall = 1'b0;
	logic     cfg_valid   = 1'b0;
	cfg_idx_t cfg_index   = REG_SAMPLE_MASK;
	data_t    cfg_data    = '0;
	logic     key_stall;
	logic     event_valid;
	logic     cfg_ready;
	keys_t    press_events;
	keys_t    release_events;
	keys_t    repeat_events;
	keys_t    held_keys;

	key_debounce_autorepeat_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.key_valid      (key_valid),
		.key_stall      (key_stall),
		.key_levels     (key_levels),
		.event_valid    (event_valid),
		.event_stall    (event_stall),
		.press_events   (press_events),
		.release_events (release_events),
		.repeat_events  (repeat_events),
		.held_keys      (held_keys),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// mirror of the block's settings and per-key lanes
	cfg_t  key_cfg;
	data_t key_hist  [NKEYS];
	logic  key_held  [NKEYS];
	data_t key_count [NKEYS];

	scan_res_t expected_events[$];
	keys_t     pending_scans[$];
	int        errors = 0;
	int        cycles = 0;
	bit        send_gaps = 1'b0;
	bit        recv_stalls = 1'b0;

	// random key behavior: each key holds a wanted level for a run of ticks
	logic want_down [NKEYS];
	int   run_left  [NKEYS];

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic hist_stable(data_t h);
		return (h & key_cfg.sample_mask) == key_cfg.sample_mask;
	endfunction

	function automatic scan_res_t debounce_tick(keys_t lv);
		scan_res_t r;
		data_t     h;
		key_ev_e   ev;
		r = '0;
		for (int k = 0; k < NKEYS; k++) begin
			h  = {key_hist[k][DATA_W-2:0], lv[k]};
			ev = EV_NONE;
			if (hist_stable(h) && !key_held[k]) begin
				ev = EV_PRESS;
				key_count[k] = key_cfg.first_delay;
				key_held[k] = 1'b1;
			end
			if (!hist_stable(h) && key_held[k]) begin
				ev = EV_RELEASE;
				h = key_cfg.off_fill;
				key_held[k] = 1'b0;
			end
			// count step looks at the history as it stands, refill included
			if (hist_stable(h) && key_count[k] != '0) begin
				key_count[k]--;
				if (key_count[k] == '0) begin
					ev = EV_REPEAT;
					key_count[k] = key_cfg.repeat_delay;
					key_held[k] = 1'b1;
				end
			end
			key_hist[k] = h;
			r.press[k]      = (ev == EV_PRESS);
			r.release_ev[k] = (ev == EV_RELEASE);
			r.repeat_ev[k]  = (ev == EV_REPEAT);
			r.held[k]       = key_held[k];
		end
		return r;
	endfunction

	function automatic keys_t next_scan(int max_run, int noise_div);
		keys_t lv;
		int    pick;
		for (int k = 0; k < NKEYS; k++) begin
			if (run_left[k] == 0) begin
				want_down[k] = !want_down[k];
				pick = int'($urandom_range(0, 9));
				if (pick < 6)
					run_left[k] = int'($urandom_range(1, 12));
				else if (pick < 9)
					run_left[k] = int'($urandom_range(10, 40));
				else
					run_left[k] = int'($urandom_range(40, max_run));
			end
			run_left[k]--;
			lv[k] = want_down[k];
			if (noise_div > 0 && $urandom_range(0, noise_div - 1) == 0)
				lv[k] = !lv[k];
		end
		return lv;
	endfunction

	function automatic void check_field(string name, keys_t want, keys_t got);
		if (want !== got) begin
			if (errors < SHOW_MAX)
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// sender: one item in flight, a random gap after each accepted item when send_gaps is set
	int send_wait = 0;
	always @(posedge clk) begin : drive_proc
		logic nv;
		if (arst_n) begin
			nv = key_valid;
			if (key_valid && !key_stall) begin
				expected_events.push_back(debounce_tick(key_levels));
				nv = 1'b0;
			end
			if (!nv) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pending_scans.size() != 0) begin
					key_levels <= pending_scans.pop_front();
					nv = 1'b1;
					send_wait = send_gaps ? int'($urandom_range(0, 8)) : 0;
				end
			end
			key_valid <= nv;
		end
	end

	// receiver: compare each accepted result, then stall for a random while when recv_stalls is set
	int recv_wait = 0;
	always @(posedge clk) begin : watch_proc
		scan_res_t got;
		scan_res_t want;
		if (arst_n) begin
			if (event_valid && !event_stall) begin
				got = {press_events, release_events, repeat_events, held_keys};
				if (expected_events.size() == 0) begin
					if (errors < SHOW_MAX)
						$display("%0t: unexpected item: expected none, actual %h", $time, got);
					errors++;
				end else begin
					want = expected_events.pop_front();
					check_field("press_events", want.press, got.press);
					check_field("release_events", want.release_ev, got.release_ev);
					check_field("repeat_events", want.repeat_ev, got.repeat_ev);
					check_field("held_keys", want.held, got.held);
				end
				recv_wait = recv_stalls ? int'($urandom_range(0, 8)) : 0;
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			event_stall <= (recv_wait > 0);
		end
	end

	task automatic write_reg(cfg_idx_t idx, data_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SAMPLE_MASK:  key_cfg.sample_mask  = val;
			REG_OFF_FILL:     key_cfg.off_fill     = val;
			REG_FIRST_DELAY:  key_cfg.first_delay  = val;
			REG_REPEAT_DELAY: key_cfg.repeat_delay = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_scans.size() != 0 || key_valid || expected_events.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// scripted scans packed one per nibble, first scan in the low nibble
	task automatic feed_scans(int n, logic [63:0] seq);
		for (int i = 0; i < n; i++)
			pending_scans.push_back(seq[4*i +: 4]);
		wait_drained();
	endtask

	task automatic run_phase(data_t mask, data_t fill, data_t first, data_t rpt,
			int n_items, int max_run, int noise_div);
		write_reg(REG_SAMPLE_MASK, mask);
		write_reg(REG_OFF_FILL, fill);
		write_reg(REG_FIRST_DELAY, first);
		write_reg(REG_REPEAT_DELAY, rpt);
		send_gaps   = ($urandom_range(0, 3) != 0);
		recv_stalls = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n_items; i++)
			pending_scans.push_back(next_scan(max_run, noise_div));
		wait_drained();
	endtask

	initial begin
		key_cfg = {SAMPLE_MASK_RST, OFF_FILL_RST, FIRST_DELAY_RST, REPEAT_DELAY_RST};
		for (int k = 0; k < NKEYS; k++) begin
			key_hist[k]  = OFF_FILL_RST;
			key_held[k]  = 1'b0;
			key_count[k] = FIRST_DELAY_RST;
			want_down[k] = 1'b0;
			run_left[k]  = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: all keys pressed, two released, then the other two
		feed_scans(8, 64'h0A5FFFF0);
		// press with a first delay of one turns into a repeat; zero repeat delay stops it
		write_reg(REG_SAMPLE_MASK, 8'h01);
		write_reg(REG_FIRST_DELAY, 8'd1);
		write_reg(REG_REPEAT_DELAY, 8'd0);
		feed_scans(6, 64'h690FFF);
		// empty mask matches every history, refill of all ones
		write_reg(REG_SAMPLE_MASK, 8'h00);
		write_reg(REG_OFF_FILL, 8'hFF);
		write_reg(REG_FIRST_DELAY, 8'd2);
		write_reg(REG_REPEAT_DELAY, 8'd1);
		feed_scans(4, 64'h30F0);
		// refill still holds the mask bits, so a repeat can replace the release
		write_reg(REG_SAMPLE_MASK, 8'h0F);
		feed_scans(6, 64'hC0F00FF);

		run_phase(8'h0F, 8'h00, 8'd10, 8'd3, 190, 60, 12);
		run_phase(8'hFF, 8'h00, 8'd255, 8'd255, 380, 320, 0);
		run_phase(8'h01, 8'h00, 8'd1, 8'd1, 180, 20, 8);
		run_phase(8'h0F, 8'hFF, 8'd2, 8'd0, 180, 40, 10);
		run_phase(8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 20)),
			8'($urandom_range(0, 20)), 150, 40, 6);
		run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)), 220, 80, 12);
		run_phase(8'h03, 8'h55, 8'd0, 8'd5, 180, 40, 10);
		run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 220, 120, 16);

		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
